// File: design/bitmap_horizontal_span_fill_assert.svh
// assertion macros for the bitmap span fill block
`ifndef BITMAP_HORIZONTAL_SPAN_FILL_ASSERT_SVH
`define BITMAP_HORIZONTAL_SPAN_FILL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BHSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bhsf assertion failed");

// next-cycle implication, checked outside reset
`define BHSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bhsf assertion failed");

`endif

// File: design/bhsf_pkg.sv
// package for the bitmap span fill block: sizes, status codes, op codes
`timescale 1ns / 1ps

package bhsf_pkg;

  localparam int FRAME_BYTES   = 4096;
  localparam int MAX_ROW_BYTES = 256;
  localparam int ADDR_W        = $clog2(FRAME_BYTES);
  localparam int RB_W          = 9;
  localparam int XW            = 11;
  localparam int YW            = 12;
  localparam int BYTE_IDX_W    = XW - 3;
  localparam int PROD_W        = YW + RB_W;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_END   = 3'd2;
  localparam logic [2:0] ST_BAD_ROW   = 3'd3;
  localparam logic [2:0] ST_ORDER     = 3'd4;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [RB_W-1:0] ROW_BYTES_RESET = 9'd80;

endpackage

// File: design/bitmap_horizontal_span_fill.sv
// top level of the bitmap span fill block: framebuffer memory and span fill sequencer
`timescale 1ns / 1ps

// 1-bit-per-pixel framebuffer of 4096 bytes in one synchronous single-port-read RAM,
// leftmost pixel in bit 7. After reset a clearing pass writes zero to every byte, one
// byte a cycle; s_tready stays low until it ends (row_bytes writes are taken
// throughout). A read item goes through S_READ, which takes the RAM byte, then S_RESULT.
// A draw item goes through S_CHECK, S_EVAL, then S_DRAW, the read-modify-write loop over
// the RAM at one byte per cycle of the span (x_end/8 - x_start/8 + 1), then S_FLUSH and
// S_RESULT; a rejected draw goes from S_EVAL to S_RESULT. One item is in work at a time;
// a finished result waits in the output register while the next item is accepted.
module bitmap_horizontal_span_fill (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x_start[10:0], x_end[21:11], row[33:22], read_addr[45:34]
  input  logic [0:0]  s_tuser,   // op
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[2:0], read_data[10:3]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bhsf_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_DRAW   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state;
  logic [ADDR_W-1:0] clr_cnt;

  logic [RB_W-1:0] row_bytes;

  logic [XW-1:0] x_s, x_e;
  logic [YW-1:0] y_r;
  logic [RB_W-1:0] rb;
  logic [PROD_W-1:0] prod;
  logic [BYTE_IDX_W-1:0] cur;
  logic [2:0] res_status;
  logic [7:0] res_data;

  logic [2:0] out_status;
  logic [7:0] out_data;

  logic wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0] wr_mask;

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rdata;
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata;

  logic in_acc, cfg_wr;
  logic [RB_W-1:0] rb_clamped;
  logic [11:0] pix_w;
  logic [2:0] eval_status;
  logic [BYTE_IDX_W-1:0] b1, b2;
  logic [7:0] m1, m2, cur_mask;
  logic [ADDR_W-1:0] cur_addr;
  logic res_load;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-RB_W){1'b0}}, row_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= ROW_BYTES_RESET;
    end else if (cfg_wr) begin
      row_bytes <= pwdata[RB_W-1:0];
    end
  end

  // ---------------- combinational helpers ----------------
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign rb_clamped = (row_bytes > RB_W'(MAX_ROW_BYTES)) ? RB_W'(MAX_ROW_BYTES) : row_bytes;
  assign pix_w = {rb, 3'b000};

  assign b1 = x_s[XW-1:3];
  assign b2 = x_e[XW-1:3];
  assign m1 = 8'hFF >> x_s[2:0];
  assign m2 = 8'hFF << (3'd7 - x_e[2:0]);
  assign cur_mask = ((cur == b1) ? m1 : 8'hFF) & ((cur == b2) ? m2 : 8'hFF);
  assign cur_addr = prod[ADDR_W-1:0] + {{(ADDR_W-BYTE_IDX_W){1'b0}}, cur};

  always_comb begin
    if ({1'b0, x_s} >= pix_w) begin
      eval_status = ST_BAD_START;
    end else if ({1'b0, x_e} >= pix_w) begin
      eval_status = ST_BAD_END;
    end else if (({1'b0, prod} + {{(PROD_W+1-RB_W){1'b0}}, rb}) > (PROD_W+1)'(FRAME_BYTES)) begin
      eval_status = ST_BAD_ROW;
    end else if (x_s > x_e) begin
      eval_status = ST_ORDER;
    end else begin
      eval_status = ST_OK;
    end
  end

  // ---------------- framebuffer memory ----------------
  assign mem_we    = (state == S_CLEAR) || wr_pend;
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : wr_addr;
  assign mem_wdata = (state == S_CLEAR) ? 8'h00 : (rdata | wr_mask);
  assign mem_raddr = (state == S_DRAW) ? cur_addr : s_tdata[45:34];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // ---------------- sequencer ----------------
  assign res_load = (state == S_RESULT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= (state == S_DRAW);
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(FRAME_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state <= (s_tuser[0] == OP_READ) ? S_READ : S_CHECK;
          end
        end
        S_CHECK: state <= S_EVAL;
        S_EVAL: state <= (eval_status == ST_OK) ? S_DRAW : S_RESULT;
        S_DRAW: begin
          if (cur == b2) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: state <= S_RESULT;
        S_READ: state <= S_RESULT;
        S_RESULT: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers of the sequencer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_s <= s_tdata[10:0];
      x_e <= s_tdata[21:11];
      y_r <= s_tdata[33:22];
    end
    if (state == S_CHECK) begin
      rb   <= rb_clamped;
      prod <= PROD_W'(y_r) * PROD_W'(rb_clamped);
    end
    if (state == S_EVAL) begin
      res_status <= eval_status;
      res_data   <= 8'h00;
      cur        <= b1;
    end
    if (state == S_DRAW) begin
      // read this byte now, or the mask into it next cycle
      wr_addr <= cur_addr;
      wr_mask <= cur_mask;
      cur     <= cur + BYTE_IDX_W'(1);
    end
    if (state == S_READ) begin
      res_status <= ST_OK;
      res_data   <= rdata;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_data   <= res_data;
    end
  end

  assign m_tdata = {5'b00000, out_data, out_status};

  // ---------------- assertions ----------------
  `include "bitmap_horizontal_span_fill_assert.svh"

  `BHSF_ASSERT_NOW(a_wr_only_after_draw, wr_pend, (state == S_DRAW) || (state == S_FLUSH))
  `BHSF_ASSERT_NOW(a_cur_in_span, state == S_DRAW, (cur >= b1) && (cur <= b2))
  `BHSF_ASSERT_NEXT(a_reject_no_write, (state == S_EVAL) && (eval_status != ST_OK), !wr_pend && (state == S_RESULT))
  `BHSF_ASSERT_NEXT(a_read_path, in_acc && (s_tuser[0] == OP_READ), state == S_READ)
  `BHSF_ASSERT_NEXT(a_result_loaded, res_load, m_tvalid && (state == S_IDLE))

endmodule

// File: tb/sv/tb.sv
// testbench for the bitmap span fill block: directed and random draws and reads, self-checking
`timescale 1ns / 1ps

module tb;
  import bhsf_pkg::*;

  localparam logic [2:0] ROW_BYTES_ADDR = 3'd0;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] pixels;
  } span_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // x_start[10:0], x_end[21:11], row[33:22], read_addr[45:34]
  logic [0:0]  s_tuser;   // op
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // status[2:0], read_data[10:3]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the framebuffer and the row length
  logic [7:0]      frame_mirror [FRAME_BYTES];
  logic [RB_W-1:0] row_len;
  span_result_t    pending_results [$];

  int fail_count;
  int cycle_count;
  bit tx_stall_en;
  bit rx_stall_en;
  int rx_hold_req;
  int last_row_base;

  bitmap_horizontal_span_fill dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int eff_row_bytes();
    return (row_len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(row_len);
  endfunction

  function automatic void or_into_frame(int addr, logic [7:0] mask);
    if (addr < FRAME_BYTES) frame_mirror[addr] = frame_mirror[addr] | mask;
  endfunction

  // works out the result of one item and applies a draw to the mirror
  function automatic span_result_t predict_span(logic op, logic [XW-1:0] xs, logic [XW-1:0] xe,
                                                logic [YW-1:0] yy, logic [ADDR_W-1:0] addr);
    span_result_t r;
    int rb;
    int pix_w;
    int base;
    int b1;
    int b2;
    logic [7:0] m1;
    logic [7:0] m2;
    r.status = ST_OK;
    r.pixels = 8'h00;
    rb = eff_row_bytes();
    pix_w = rb * 8;
    if (op == OP_READ) begin
      r.pixels = frame_mirror[addr];
    end else if (int'(xs) >= pix_w) begin
      r.status = ST_BAD_START;
    end else if (int'(xe) >= pix_w) begin
      r.status = ST_BAD_END;
    end else if ((int'(yy) + 1) * rb > FRAME_BYTES) begin
      r.status = ST_BAD_ROW;
    end else if (xs > xe) begin
      r.status = ST_ORDER;
    end else begin
      base = int'(yy) * rb;
      b1 = int'(xs) >> 3;
      b2 = int'(xe) >> 3;
      m1 = 8'hFF >> xs[2:0];
      m2 = 8'hFF << (3'd7 - xe[2:0]);
      if (b1 == b2) begin
        or_into_frame(base + b1, m1 & m2);
      end else begin
        or_into_frame(base + b1, m1);
        for (int i = b1 + 1; i < b2; i++) or_into_frame(base + i, 8'hFF);
        or_into_frame(base + b2, m2);
      end
    end
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // one transaction on the input stream; valid is left high for a following item
  task automatic send_item(logic op, logic [XW-1:0] xs, logic [XW-1:0] xe,
                           logic [YW-1:0] yy, logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    if (tx_stall_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, addr, yy, xe, xs};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_span(op, xs, xe, yy, addr));
  endtask

  task automatic draw(int xs, int xe, int yy);
    send_item(OP_DRAW, xs[XW-1:0], xe[XW-1:0], yy[YW-1:0],
              ADDR_W'($urandom_range(0, FRAME_BYTES - 1)));
  endtask

  task automatic read_byte(int addr);
    send_item(OP_READ, XW'($urandom_range(0, 2047)), XW'($urandom_range(0, 2047)),
              YW'($urandom_range(0, 4095)), addr[ADDR_W-1:0]);
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_row_bytes(logic [RB_W-1:0] value);
    logic [31:0] word;
    wait_for_results();
    word = $urandom;
    word[RB_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROW_BYTES_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    row_len = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one random item: mostly well-formed spans and reads near them, some noise
  task automatic random_item();
    int kind;
    int rb;
    int pix_w;
    int height;
    int xs;
    int xe;
    int yy;
    rb = eff_row_bytes();
    pix_w = rb * 8;
    height = (rb == 0) ? 0 : FRAME_BYTES / rb;
    kind = $urandom_range(0, 99);
    if (kind < 45 && height > 0) begin
      xs = $urandom_range(0, pix_w - 1);
      xe = ($urandom_range(0, 9) == 0) ? $urandom_range(xs, pix_w - 1)
                                       : xs + $urandom_range(0, 31);
      if (xe > pix_w - 1) xe = pix_w - 1;
      yy = $urandom_range(0, height - 1);
      last_row_base = yy * rb;
      draw(xs, xe, yy);
    end else if (kind < 80) begin
      if ($urandom_range(0, 1) == 0 && rb > 0)
        read_byte((last_row_base + $urandom_range(0, rb - 1)) % FRAME_BYTES);
      else
        read_byte($urandom_range(0, FRAME_BYTES - 1));
    end else begin
      send_item(1'($urandom_range(0, 1)), XW'($urandom_range(0, 2047)),
                XW'($urandom_range(0, 2047)), YW'($urandom_range(0, 4095)),
                ADDR_W'($urandom_range(0, FRAME_BYTES - 1)));
    end
  endtask

  // screen must read back cleared after the clearing pass
  task automatic test_after_reset();
    read_byte(0);
    read_byte(FRAME_BYTES - 1);
    read_byte(1234);
  endtask

  task automatic test_directed_spans();
    draw(3, 5, 0);          // both ends in one byte
    read_byte(0);
    draw(0, 639, 50);       // whole bottom row
    read_byte(4000);
    read_byte(4079);
    draw(10, 29, 1);        // partial ends with a full byte between
    read_byte(81);
    read_byte(82);
    read_byte(83);
    draw(639, 639, 0);      // rightmost pixel alone
    read_byte(79);
    draw(640, 700, 0);
    draw(2047, 2047, 0);
    draw(0, 640, 0);
    draw(0, 2047, 4095);
    draw(0, 7, 51);
    draw(0, 7, 4095);
    draw(9, 8, 0);
    draw(639, 0, 0);
  endtask

  task automatic test_row_length_extremes();
    set_row_bytes(9'd256);
    draw(0, 2047, 15);
    draw(0, 0, 16);
    read_byte(FRAME_BYTES - 1);
    set_row_bytes(9'd1);
    draw(0, 7, 4095);
    draw(8, 8, 0);
    set_row_bytes(9'd0);
    draw(0, 0, 0);
    read_byte(0);
    set_row_bytes(9'd511);  // clamped to the widest row
    draw(2040, 2047, 0);
    draw(0, 0, 16);
    read_byte(255);
  endtask

  task automatic test_random_traffic(int n_items);
    repeat (n_items) random_item();
  endtask

  // output held off for a long stretch while input keeps coming, then a full drain
  task automatic test_output_backpressure();
    set_row_bytes(ROW_BYTES_RESET);
    rx_hold_req = 400;
    repeat (24) random_item();
    wait_for_results();
  endtask

  // receiver: random stall bursts plus an optional long hold
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        m_tready <= 1'b0;
        rx_hold_req--;
      end else if (burst > 0) begin
        m_tready <= 1'b0;
        burst--;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        burst = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    span_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d data %02h",
                               m_tdata[2:0], m_tdata[10:3]));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[2:0] !== want.status || m_tdata[10:3] !== want.pixels)
          note_failure($sformatf("mismatch: status exp %0d got %0d, data exp %02h got %02h",
                                 want.status, m_tdata[2:0], want.pixels, m_tdata[10:3]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int widths [8];
    widths = '{80, 1, 256, 7, 300, 511, 33, 160};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    cycle_count = 0;
    tx_stall_en = 1'b1;
    rx_stall_en = 1'b1;
    rx_hold_req = 0;
    last_row_base = 0;
    row_len = ROW_BYTES_RESET;
    foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_directed_spans();
    test_row_length_extremes();
    foreach (widths[i]) begin
      set_row_bytes(widths[i][RB_W-1:0]);
      test_random_traffic(160);
    end
    set_row_bytes(9'd0);
    test_random_traffic(30);
    test_output_backpressure();
    // closing stretch with no idling on either side
    tx_stall_en = 1'b0;
    rx_stall_en = 1'b0;
    set_row_bytes(9'd64);
    test_random_traffic(250);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) note_failure("results missing at end of run");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/bhsf_pkg.sv
design/bitmap_horizontal_span_fill.sv
tb/sv/tb.sv
